// ===== rtl/bcs_pkg.sv =====
package bcs_pkg;

   localparam int CFG_WIDTH = 16;
   localparam int CFG_ADDR_WIDTH = 3;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_RISE     = 3'd1;
   localparam logic [2:0] ST_PRESSED  = 3'd2;
   localparam logic [2:0] ST_FALL     = 3'd3;
   localparam logic [2:0] ST_RELEASED = 3'd4;
   localparam logic [2:0] ST_SWON     = 3'd5;
   localparam logic [2:0] ST_SWOFF    = 3'd6;

   localparam logic [3:0] EV_NONE   = 4'd0;
   localparam logic [3:0] EV_SINGLE = 4'd1;
   localparam logic [3:0] EV_HOLD_A = 4'd5;
   localparam logic [3:0] EV_HOLD_B = 4'd6;
   localparam logic [3:0] EV_HOLD_C = 4'd7;
   localparam logic [3:0] EV_HOLD_D = 4'd8;
   localparam logic [3:0] EV_SW_ON  = 4'd9;
   localparam logic [3:0] EV_SW_OFF = 4'd10;

   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_TOGGLE = 2'd1;
   localparam logic [1:0] MODE_KILL   = 2'd2;

   localparam logic [CFG_ADDR_WIDTH-1:0] REG_BUTTON_MODE = 3'd0;
   localparam logic [CFG_ADDR_WIDTH-1:0] REG_DEBOUNCE    = 3'd1;
   localparam logic [CFG_ADDR_WIDTH-1:0] REG_REPEAT      = 3'd2;
   localparam logic [CFG_ADDR_WIDTH-1:0] REG_GAP         = 3'd3;
   localparam logic [CFG_ADDR_WIDTH-1:0] REG_HOLD_A      = 3'd4;
   localparam logic [CFG_ADDR_WIDTH-1:0] REG_HOLD_B      = 3'd5;
   localparam logic [CFG_ADDR_WIDTH-1:0] REG_HOLD_C      = 3'd6;
   localparam logic [CFG_ADDR_WIDTH-1:0] REG_HOLD_D      = 3'd7;

   typedef struct packed {
      logic [1:0]           button_mode;
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] repeat_ms;
      logic [CFG_WIDTH-1:0] multi_click_gap_ms;
      logic [CFG_WIDTH-1:0] hold_a_ms;
      logic [CFG_WIDTH-1:0] hold_b_ms;
      logic [CFG_WIDTH-1:0] hold_c_ms;
      logic [CFG_WIDTH-1:0] hold_d_ms;
   } cfg_type;

   typedef struct packed {
      logic [3:0] event_code;
      logic       event_final;
      logic       lamp_on;
      logic       switch_level;
   } result_type;

endpackage

// ===== rtl/button_click_hold_switch_fsm_top.sv =====
// Latency: a result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one tick per cycle while the output register is empty or rsp_tready is high;
// the FSM and timer update is a single registered pass; a waiting result stalls new ticks.
// Reset: synchronous, active high; FSM idle, flags, count and timers cleared,
// configuration registers back to their default values, output register empty.
module button_click_hold_switch_fsm_top #(
   parameter int TIMER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [0] pressed, [1] rise_seen,
                                                           // [2] fall_seen
   input  logic                                req_tuser,  // [0] action
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [3:0] event_code, [4] lamp_on,
                                                           // [5] switch_level
   output logic                                rsp_tlast,  // event_final
   input  logic                                csr_we,
   input  logic [bcs_pkg::CFG_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [bcs_pkg::CFG_WIDTH-1:0]       csr_wdata
);
   import bcs_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   bcs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcs_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .action    (req_tuser),
      .pressed   (req_tdata[0]),
      .rise_seen (req_tdata[1]),
      .fall_seen (req_tdata[2]),
      .result    (result)
   );

   always_comb begin
      if (accept)          rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.switch_level, rsp_ff.lamp_on, rsp_ff.event_code};
   assign rsp_tlast  = rsp_ff.event_final;

endmodule

// ===== rtl/bcs_cfg.sv =====
module bcs_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bcs_pkg::CFG_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [bcs_pkg::CFG_WIDTH-1:0]       csr_wdata,
   output bcs_pkg::cfg_type                    cfg
);
   import bcs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_BUTTON_MODE: cfg_in.button_mode = csr_wdata[1:0];
            REG_DEBOUNCE:    cfg_in.debounce_ms = csr_wdata;
            REG_REPEAT:      cfg_in.repeat_ms = csr_wdata;
            REG_GAP:         cfg_in.multi_click_gap_ms = csr_wdata;
            REG_HOLD_A:      cfg_in.hold_a_ms = csr_wdata;
            REG_HOLD_B:      cfg_in.hold_b_ms = csr_wdata;
            REG_HOLD_C:      cfg_in.hold_c_ms = csr_wdata;
            REG_HOLD_D:      cfg_in.hold_d_ms = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_mode        <= MODE_PUSH;
         cfg_ff.debounce_ms        <= 16'd50;
         cfg_ff.repeat_ms          <= 16'd200;
         cfg_ff.multi_click_gap_ms <= 16'd300;
         cfg_ff.hold_a_ms          <= 16'd2000;
         cfg_ff.hold_b_ms          <= 16'd5000;
         cfg_ff.hold_c_ms          <= 16'd10000;
         cfg_ff.hold_d_ms          <= 16'd20000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bcs_core.sv =====
module bcs_core #(
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bcs_pkg::cfg_type      cfg,
   input  logic                  accept,
   input  logic                  action,
   input  logic                  pressed,
   input  logic                  rise_seen,
   input  logic                  fall_seen,
   output bcs_pkg::result_type   result
);
   import bcs_pkg::*;

   // compare width covers both timers and 16-bit thresholds
   localparam int CW = (TIMER_BITS > CFG_WIDTH) ? TIMER_BITS : CFG_WIDTH;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic [2:0]            st_ff, st_in;
   logic                  rpend_ff, rpend_in, fpend_ff, fpend_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic                  sw_ff, sw_in, lamp_ff, lamp_in;
   logic [TIMER_BITS-1:0] ph_ff, ph_in, pr_ff, pr_in, rt_ff, rt_in;

   logic                  kill, swmode;
   logic [CW-1:0]         debounce_x, repeat_x, gap_x, ha_x, hb_x, hc_x, hd_x;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
      sat_inc = (t == TMAX) ? t : t + 1'b1;
   endfunction

   function automatic logic [3:0] click_code(
      input logic [2:0] cnt, input logic [CW-1:0] d,
      input logic [CW-1:0] a, input logic [CW-1:0] b,
      input logic [CW-1:0] c, input logic [CW-1:0] e);
      logic [3:0] code;
      code = EV_NONE;
      if (cnt <= 3'd1) begin
         if (d >= a && d < b)      code = EV_HOLD_A;
         else if (d >= b && d < c) code = EV_HOLD_B;
         else if (d >= c && d < e) code = EV_HOLD_C;
         else if (d >= e)          code = EV_HOLD_D;
         else if (cnt == 3'd1)     code = EV_SINGLE;
      end else if (cnt <= 3'd4) begin
         code = {1'b0, cnt};
      end
      click_code = code;
   endfunction

   assign kill   = (cfg.button_mode == MODE_KILL);
   assign swmode = (cfg.button_mode == MODE_TOGGLE) || kill;

   assign debounce_x = CW'(cfg.debounce_ms);
   assign repeat_x   = CW'(cfg.repeat_ms);
   assign gap_x      = CW'(cfg.multi_click_gap_ms);
   assign ha_x       = CW'(cfg.hold_a_ms);
   assign hb_x       = CW'(cfg.hold_b_ms);
   assign hc_x       = CW'(cfg.hold_c_ms);
   assign hd_x       = CW'(cfg.hold_d_ms);

   always_comb begin
      logic                  rp, fp, ent;
      logic [2:0]            tgt, cnt;
      logic [TIMER_BITS-1:0] ph, pr, rt;
      logic [3:0]            ev;
      logic                  fin;

      rp  = rpend_ff | rise_seen;
      fp  = fpend_ff | fall_seen;
      ph  = sat_inc(ph_ff);
      pr  = sat_inc(pr_ff);
      rt  = sat_inc(rt_ff);
      cnt = cnt_ff;
      ent = 1'b0;
      tgt = ST_IDLE;
      ev  = EV_NONE;
      fin = 1'b0;

      if (action) begin
         rp  = rpend_ff;
         fp  = fpend_ff;
         ph  = ph_ff;
         pr  = '0;
         rt  = rt_ff;
         ent = 1'b1;
         tgt = ST_PRESSED;
      end else begin
         case (st_ff)
            ST_IDLE: begin
               if (rp) begin
                  ent = 1'b1;
                  tgt = ST_RISE;
               end
            end
            ST_RISE: begin
               if (CW'(ph) >= debounce_x) begin
                  ent = 1'b1;
                  if (pressed) begin
                     if (kill) begin
                        ev  = EV_SW_ON;
                        fin = 1'b1;
                        tgt = ST_SWON;
                     end else begin
                        tgt = ST_PRESSED;
                     end
                  end else if (swmode) begin
                     tgt = sw_ff ? ST_SWON : ST_SWOFF;
                  end else begin
                     tgt = ST_IDLE;
                  end
               end
            end
            ST_PRESSED: begin
               if (fp) begin
                  ent = 1'b1;
                  if (swmode) begin
                     fin = 1'b1;
                     if (!kill && sw_ff) begin
                        ev  = EV_SW_OFF;
                        tgt = ST_SWOFF;
                     end else begin
                        ev  = EV_SW_ON;
                        tgt = ST_SWON;
                     end
                  end else begin
                     if (cnt != 3'd7) cnt = cnt + 3'd1;
                     ev  = click_code(cnt, CW'(pr), ha_x, hb_x, hc_x, hd_x);
                     tgt = ST_FALL;
                  end
               end else if (!kill && CW'(rt) >= repeat_x) begin
                  rt = '0;
                  ev = click_code(cnt, CW'(pr), ha_x, hb_x, hc_x, hd_x);
               end
            end
            ST_FALL: begin
               if (CW'(ph) >= debounce_x) begin
                  ent = 1'b1;
                  if (swmode) begin
                     ev  = EV_SW_OFF;
                     fin = 1'b1;
                     tgt = ST_SWOFF;
                  end else begin
                     tgt = ST_RELEASED;
                  end
               end
            end
            ST_RELEASED: begin
               if (rp) begin
                  ent = 1'b1;
                  tgt = ST_RISE;
               end else if (CW'(ph) >= gap_x) begin
                  ev  = click_code(cnt, CW'(pr), ha_x, hb_x, hc_x, hd_x);
                  fin = (ev != EV_NONE);
                  ent = 1'b1;
                  tgt = ST_IDLE;
               end
            end
            ST_SWON: begin
               if (!kill) begin
                  if (rp) begin
                     ent = 1'b1;
                     tgt = ST_RISE;
                  end
               end else if (fp) begin
                  ent = 1'b1;
                  tgt = ST_FALL;
               end
            end
            ST_SWOFF: begin
               if (rp) begin
                  ent = 1'b1;
                  tgt = ST_RISE;
               end
            end
            default: begin
               ent = 1'b1;
               tgt = ST_IDLE;
            end
         endcase
      end

      st_in    = st_ff;
      rpend_in = rp;
      fpend_in = fp;
      ph_in    = ph;
      pr_in    = pr;
      rt_in    = rt;
      cnt_in   = cnt;
      sw_in    = sw_ff;
      lamp_in  = lamp_ff;

      if (ent) begin
         rpend_in = 1'b0;
         fpend_in = 1'b0;
         ph_in    = '0;
         if (tgt == ST_IDLE) begin
            cnt_in = '0;
            if (kill) tgt = pressed ? ST_SWON : ST_SWOFF;
         end
         st_in = tgt;
         case (tgt)
            ST_RISE:    pr_in = '0;
            ST_PRESSED: rt_in = '0;
            ST_SWON: begin
               sw_in   = 1'b1;
               lamp_in = 1'b1;
            end
            ST_SWOFF: begin
               sw_in   = 1'b0;
               lamp_in = 1'b0;
            end
            default: ;
         endcase
      end

      result.event_code   = ev;
      result.event_final  = fin;
      result.lamp_on      = lamp_in;
      result.switch_level = sw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         rpend_ff <= 1'b0;
         fpend_ff <= 1'b0;
         cnt_ff   <= '0;
         sw_ff    <= 1'b0;
         lamp_ff  <= 1'b0;
         ph_ff    <= '0;
         pr_ff    <= '0;
         rt_ff    <= '0;
      end else if (accept) begin
         st_ff    <= st_in;
         rpend_ff <= rpend_in;
         fpend_ff <= fpend_in;
         cnt_ff   <= cnt_in;
         sw_ff    <= sw_in;
         lamp_ff  <= lamp_in;
         ph_ff    <= ph_in;
         pr_ff    <= pr_in;
         rt_ff    <= rt_in;
      end
   end

`ifndef ASSERT_OFF
   a_lamp_tracks_switch: assert property (@(posedge clock) disable iff (reset)
      lamp_ff == sw_ff)
      else $error("lamp and switch state diverged");

   a_force_enters_pressed: assert property (@(posedge clock) disable iff (reset)
      accept && action |=> st_ff == ST_PRESSED && pr_ff == '0 && rt_ff == '0)
      else $error("forced press did not enter pressed state");

   a_final_has_event: assert property (@(posedge clock) disable iff (reset)
      accept && result.event_final |-> result.event_code != EV_NONE)
      else $error("final flag without event");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(st_ff) && $stable(cnt_ff) && $stable(ph_ff))
      else $error("state moved without a transaction");
`endif

endmodule

// ===== bench/button_event_checker.sv =====
module button_event_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [0] pressed, [1] rise_seen,
                                                          // [2] fall_seen
   input  logic                               req_tuser,  // [0] action
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [7:0]                         rsp_tdata,  // [3:0] event_code, [4] lamp_on,
                                                          // [5] switch_level
   input  logic                               rsp_tlast,  // event_final
   input  logic                               csr_we,
   input  logic [bcs_pkg::CFG_ADDR_WIDTH-1:0] csr_addr,
   input  logic [bcs_pkg::CFG_WIDTH-1:0]      csr_wdata,
   output int                                 mismatches,
   output int                                 pending
);
   import bcs_pkg::*;

   localparam logic [15:0] TIMER_FULL = 16'hFFFF;

   cfg_type     cfg;
   logic [2:0]  fsm;
   logic        rise_pend;
   logic        fall_pend;
   logic        switch_on;
   logic        lamp_lit;
   logic [2:0]  clicks;
   logic [15:0] phase_ticks;
   logic [15:0] press_ticks;
   logic [15:0] repeat_ticks;
   logic [3:0]  ev_code;
   logic        ev_final;
   result_type  expected_events[$];

   initial begin
      mismatches = 0;
      pending = 0;
   end

   function automatic logic [15:0] sat_inc(logic [15:0] t);
      return (t == TIMER_FULL) ? t : t + 16'd1;
   endfunction

   function automatic bit kill_mode();
      return cfg.button_mode == MODE_KILL;
   endfunction

   function automatic bit switch_mode();
      return cfg.button_mode == MODE_TOGGLE || cfg.button_mode == MODE_KILL;
   endfunction

   function automatic void clear_button();
      cfg.button_mode        = MODE_PUSH;
      cfg.debounce_ms        = 16'd50;
      cfg.repeat_ms          = 16'd200;
      cfg.multi_click_gap_ms = 16'd300;
      cfg.hold_a_ms          = 16'd2000;
      cfg.hold_b_ms          = 16'd5000;
      cfg.hold_c_ms          = 16'd10000;
      cfg.hold_d_ms          = 16'd20000;
      fsm          = ST_IDLE;
      rise_pend    = 1'b0;
      fall_pend    = 1'b0;
      switch_on    = 1'b0;
      lamp_lit     = 1'b0;
      clicks       = 3'd0;
      phase_ticks  = 16'd0;
      press_ticks  = 16'd0;
      repeat_ticks = 16'd0;
   endfunction

   // kill mode never rests in idle: it drops straight into on or off
   function automatic void go_state(logic [2:0] s, logic lvl);
      logic [2:0] nxt;
      nxt = s;
      rise_pend = 1'b0;
      fall_pend = 1'b0;
      phase_ticks = 16'd0;
      if (s == ST_IDLE) begin
         clicks = 3'd0;
         if (kill_mode())
            nxt = lvl ? ST_SWON : ST_SWOFF;
      end else if (s == ST_RISE) begin
         press_ticks = 16'd0;
      end else if (s == ST_PRESSED) begin
         repeat_ticks = 16'd0;
      end
      fsm = nxt;
      if (nxt == ST_SWON) begin
         switch_on = 1'b1;
         lamp_lit = 1'b1;
      end else if (nxt == ST_SWOFF) begin
         switch_on = 1'b0;
         lamp_lit = 1'b0;
      end
   endfunction

   function automatic void classify_press(logic [2:0] cnt, logic fin);
      logic [3:0] code;
      code = EV_NONE;
      if (cnt <= 3'd1) begin
         if (press_ticks >= cfg.hold_a_ms && press_ticks < cfg.hold_b_ms)
            code = EV_HOLD_A;
         else if (press_ticks >= cfg.hold_b_ms && press_ticks < cfg.hold_c_ms)
            code = EV_HOLD_B;
         else if (press_ticks >= cfg.hold_c_ms && press_ticks < cfg.hold_d_ms)
            code = EV_HOLD_C;
         else if (press_ticks >= cfg.hold_d_ms)
            code = EV_HOLD_D;
         else if (cnt == 3'd1)
            code = EV_SINGLE;
      end else if (cnt <= 3'd4) begin
         code = {1'b0, cnt};
      end
      ev_code = code;
      ev_final = (code != EV_NONE) && fin;
   endfunction

   function automatic void flip_report(logic on);
      ev_code = on ? EV_SW_ON : EV_SW_OFF;
      ev_final = 1'b1;
   endfunction

   function automatic void run_fsm(logic lvl);
      case (fsm)
         ST_IDLE: begin
            if (rise_pend)
               go_state(ST_RISE, lvl);
         end
         ST_RISE: begin
            if (phase_ticks >= cfg.debounce_ms) begin
               if (lvl) begin
                  if (kill_mode()) begin
                     flip_report(1'b1);
                     go_state(ST_SWON, lvl);
                  end else begin
                     go_state(ST_PRESSED, lvl);
                  end
               end else if (switch_mode()) begin
                  go_state(switch_on ? ST_SWON : ST_SWOFF, lvl);
               end else begin
                  go_state(ST_IDLE, lvl);
               end
            end
         end
         ST_PRESSED: begin
            if (fall_pend) begin
               if (switch_mode()) begin
                  if (!kill_mode() && switch_on) begin
                     flip_report(1'b0);
                     go_state(ST_SWOFF, lvl);
                  end else begin
                     flip_report(1'b1);
                     go_state(ST_SWON, lvl);
                  end
               end else begin
                  if (clicks < 3'd7)
                     clicks = clicks + 3'd1;
                  classify_press(clicks, 1'b0);
                  go_state(ST_FALL, lvl);
               end
            end else if (!kill_mode() && repeat_ticks >= cfg.repeat_ms) begin
               repeat_ticks = 16'd0;
               classify_press(clicks, 1'b0);
            end
         end
         ST_FALL: begin
            if (phase_ticks >= cfg.debounce_ms) begin
               if (switch_mode()) begin
                  flip_report(1'b0);
                  go_state(ST_SWOFF, lvl);
               end else begin
                  go_state(ST_RELEASED, lvl);
               end
            end
         end
         ST_RELEASED: begin
            if (rise_pend) begin
               go_state(ST_RISE, lvl);
            end else if (phase_ticks >= cfg.multi_click_gap_ms) begin
               classify_press(clicks, 1'b1);
               go_state(ST_IDLE, lvl);
            end
         end
         ST_SWON: begin
            if (!kill_mode()) begin
               if (rise_pend)
                  go_state(ST_RISE, lvl);
            end else if (fall_pend) begin
               go_state(ST_FALL, lvl);
            end
         end
         ST_SWOFF: begin
            if (rise_pend)
               go_state(ST_RISE, lvl);
         end
         default: begin
            go_state(ST_IDLE, lvl);
         end
      endcase
   endfunction

   function automatic result_type next_button_event(logic act, logic lvl, logic rise,
                                                    logic fall);
      result_type r;
      ev_code = EV_NONE;
      ev_final = 1'b0;
      if (act) begin
         press_ticks = 16'd0;
         go_state(ST_PRESSED, lvl);
      end else begin
         if (rise)
            rise_pend = 1'b1;
         if (fall)
            fall_pend = 1'b1;
         phase_ticks = sat_inc(phase_ticks);
         press_ticks = sat_inc(press_ticks);
         repeat_ticks = sat_inc(repeat_ticks);
         run_fsm(lvl);
      end
      r.event_code = ev_code;
      r.event_final = ev_final;
      r.lamp_on = lamp_lit;
      r.switch_level = switch_on;
      return r;
   endfunction

   function automatic void log_failure(string what, result_type want, result_type seen);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected code=%0d final=%0b lamp=%0b switch=%0b,", $realtime,
                  what, want.event_code, want.event_final, want.lamp_on, want.switch_level,
                  " got code=%0d final=%0b lamp=%0b switch=%0b", seen.event_code,
                  seen.event_final, seen.lamp_on, seen.switch_level);
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      result_type seen;
      if (reset) begin
         clear_button();
         expected_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.event_code = rsp_tdata[3:0];
            seen.lamp_on = rsp_tdata[4];
            seen.switch_level = rsp_tdata[5];
            seen.event_final = rsp_tlast;
            if (expected_events.size() == 0) begin
               log_failure("unexpected transaction", '0, seen);
            end else begin
               want = expected_events.pop_front();
               if (want.event_code != seen.event_code ||
                   want.event_final != seen.event_final ||
                   want.lamp_on != seen.lamp_on ||
                   want.switch_level != seen.switch_level)
                  log_failure("event mismatch", want, seen);
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_BUTTON_MODE: cfg.button_mode = csr_wdata[1:0];
               REG_DEBOUNCE:    cfg.debounce_ms = csr_wdata;
               REG_REPEAT:      cfg.repeat_ms = csr_wdata;
               REG_GAP:         cfg.multi_click_gap_ms = csr_wdata;
               REG_HOLD_A:      cfg.hold_a_ms = csr_wdata;
               REG_HOLD_B:      cfg.hold_b_ms = csr_wdata;
               REG_HOLD_C:      cfg.hold_c_ms = csr_wdata;
               REG_HOLD_D:      cfg.hold_d_ms = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_events.push_back(next_button_event(req_tuser, req_tdata[0],
                                                        req_tdata[1], req_tdata[2]));
      end
      pending = expected_events.size();
   end

endmodule

// ===== bench/tb.sv =====
module tb;
   import bcs_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;  // [0] pressed, [1] rise_seen, [2] fall_seen
   logic                      req_tuser;  // [0] action
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [7:0]                rsp_tdata;  // [3:0] event_code, [4] lamp_on, [5] switch_level
   logic                      rsp_tlast;  // event_final
   logic                      csr_we;
   logic [CFG_ADDR_WIDTH-1:0] csr_addr;
   logic [CFG_WIDTH-1:0]      csr_wdata;

   int errors;
   int pending;
   int cycles = 0;
   bit req_gaps = 1'b0;
   bit rsp_gaps = 1'b0;
   bit hold_off_req = 1'b0;

   always #5 clock = ~clock;

   button_click_hold_switch_fsm_top #(.TIMER_BITS(16)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   button_event_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (errors),
      .pending    (pending)
   );

   function automatic int idle_len();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40))
                                         : int'($urandom_range(1, 3));
   endfunction

   task automatic put(bit act, bit lvl, bit rise, bit fall);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {5'b0, fall, rise, lvl};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(logic [CFG_ADDR_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] mode_word, logic [15:0] deb, logic [15:0] rep,
                             logic [15:0] gap, logic [15:0] a, logic [15:0] b,
                             logic [15:0] c, logic [15:0] d);
      write_reg(REG_BUTTON_MODE, mode_word);
      write_reg(REG_DEBOUNCE, deb);
      write_reg(REG_REPEAT, rep);
      write_reg(REG_GAP, gap);
      write_reg(REG_HOLD_A, a);
      write_reg(REG_HOLD_B, b);
      write_reg(REG_HOLD_C, c);
      write_reg(REG_HOLD_D, d);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic random_config(bit [1:0] mode);
      logic [15:0] mw;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
      logic [15:0] d;
      mw = 16'($urandom);
      mw[1:0] = mode;
      if ($urandom_range(0, 3) == 0) begin
         // bands out of order
         a = 16'($urandom_range(0, 40));
         b = 16'($urandom_range(0, 40));
         c = 16'($urandom_range(0, 40));
         d = 16'($urandom_range(0, 40));
      end else begin
         a = 16'($urandom_range(0, 8));
         b = a + 16'($urandom_range(0, 12));
         c = b + 16'($urandom_range(0, 12));
         d = c + 16'($urandom_range(0, 15));
      end
      set_config(mw, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                 16'($urandom_range(0, 10)), a, b, c, d);
   endtask

   task automatic press_and_release(output int count);
      int hold;
      int rel;
      hold = ($urandom_range(0, 7) == 0) ? int'($urandom_range(30, 80))
                                          : int'($urandom_range(0, 20));
      rel = int'($urandom_range(0, 14));
      put(1'b0, 1'b1, 1'b1, $urandom_range(0, 3) == 0);
      for (int k = 0; k < hold; k++)
         put(1'b0, !(k < 2 && $urandom_range(0, 2) == 0), $urandom_range(0, 24) == 0,
             $urandom_range(0, 59) == 0);
      put(1'b0, 1'b0, $urandom_range(0, 5) == 0, 1'b1);
      for (int k = 0; k < rel; k++)
         put(1'b0, 1'b0, $urandom_range(0, 24) == 0, 1'b0);
      count = hold + rel + 2;
   endtask

   task automatic random_ticks(int n);
      int done;
      int got;
      done = 0;
      while (done < n) begin
         case ($urandom_range(0, 9))
            0: begin
               put(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
               done++;
            end
            1: begin
               put(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
               done++;
            end
            default: begin
               press_and_release(got);
               done += got;
            end
         endcase
      end
      drain();
   endtask

   initial begin : rsp_side
      rsp_tready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
         end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      bit [1:0] mode;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // mode 3 behaves as push; forced presses walk the click count into saturation
      set_config(16'hFFFF, 16'd0, 16'd3, 16'd2, 16'd4, 16'd6, 16'd8, 16'd10);
      put(1'b0, 1'b0, 1'b0, 1'b0);
      put(1'b0, 1'b1, 1'b1, 1'b1);
      repeat (3) put(1'b0, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 8; i++) begin
         put(1'b1, i[0], 1'b1, 1'b1);
         put(1'b0, 1'b0, 1'b0, 1'b1);
      end
      repeat (3) put(1'b0, 1'b0, 1'b0, 1'b0);
      drain();

      // one long press climbs through the low hold bands; the top bands stay out of reach
      set_config({14'h3FFF, MODE_PUSH}, 16'd2, 16'd25, 16'd3, 16'd20, 16'd40,
                 16'hFFFE, 16'hFFFF);
      put(1'b0, 1'b1, 1'b1, 1'b0);
      repeat (60) put(1'b0, 1'b1, 1'b0, 1'b0);
      put(1'b0, 1'b0, 1'b0, 1'b1);
      repeat (4) put(1'b0, 1'b0, 1'b0, 1'b0);
      drain();

      for (int p = 0; p < 12; p++) begin
         mode = p[1:0];
         req_gaps = (p % 3) != 0;
         rsp_gaps = (p % 3) != 1;
         random_config(mode);
         if (p == 5) begin
            req_gaps = 1'b0;
            hold_off_req = 1'b1;
         end
         random_ticks(80);
      end

      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      set_config({14'h3FFF, MODE_KILL}, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF);
      random_ticks(50);
      set_config({14'h0, MODE_TOGGLE}, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      random_ticks(40);
      set_config({14'h0, MODE_PUSH}, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      random_ticks(40);

      repeat (4) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
